### rtl/miu_pkg.sv
`timescale 1ns / 1ps

package miu_pkg;

  // Fixed width of the item fields on the channels
  localparam int unsigned MIU_FIELD_W   = 64;
  // Default operand width of the arithmetic
  localparam int unsigned MIU_WIDTH_DEF = 64;

  // Control from the sequencer to the shared divide unit
  typedef struct packed {
    logic start;
  } miu_div_ctl_t;

  // Status from the shared divide unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } miu_div_sts_t;

endpackage

### rtl/miu_in_if.sv
`timescale 1ns / 1ps

interface miu_in_if import miu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MIU_FIELD_W-1:0] value;
  logic [MIU_FIELD_W-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

### rtl/miu_out_if.sv
`timescale 1ns / 1ps

interface miu_out_if import miu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MIU_FIELD_W-1:0] inverse;
  logic                   no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

### rtl/modular_inverse_unit_core.sv
`timescale 1ns / 1ps

// Modular inverse by the extended Euclidean algorithm on one shared divider.
// The value is first reduced modulo the modulus by one divide, then each Euclid step
// runs one divide, up to about 93 steps at WIDTH = 64; a zero modulus answers with
// no inverse and uses no divide.
// Throughput: one item at a time; the next is taken the cycle after the result
// is registered, later while a finished result waits for the output to drain.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module modular_inverse_unit_core import miu_pkg::*; #(
  parameter int unsigned WIDTH = MIU_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  miu_in_if.sink    in_i,
  miu_out_if.source out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_LOOP = 3'd2;
  localparam logic [2:0] ST_ITER = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_SGN  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] r0_q, r0_d;
  logic [WIDTH-1:0] r1_q, r1_d;
  logic [WIDTH-1:0] s0_q, s0_d;
  logic [WIDTH-1:0] s1_q, s1_d;
  logic             neg0_q, neg0_d;
  logic             neg1_q, neg1_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             flag_q, flag_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_inv_q, out_inv_d;
  logic             out_flag_q, out_flag_d;

  miu_div_ctl_t     div_ctl;
  miu_div_sts_t     div_sts;
  logic [WIDTH-1:0] div_n;
  logic [WIDTH-1:0] div_d;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH-1:0] div_prod;
  logic [WIDTH-1:0] in_val;
  logic [WIDTH-1:0] in_mod;

  assign in_val = in_i.value[WIDTH-1:0];
  assign in_mod = in_i.modulus[WIDTH-1:0];

  miu_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .mult_i     (s1_q),
    .sts_o      (div_sts),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // Sequence the Euclid steps
  always_comb begin
    state_d       = state_q;
    m_d           = m_q;
    r0_d          = r0_q;
    r1_d          = r1_q;
    s0_d          = s0_q;
    s1_d          = s1_q;
    neg0_d        = neg0_q;
    neg1_d        = neg1_q;
    res_d         = res_q;
    flag_d        = flag_q;
    out_valid_d   = out_valid_q;
    out_inv_d     = out_inv_q;
    out_flag_d    = out_flag_q;
    div_ctl.start = 1'b0;
    div_n         = r0_q;
    div_d         = r1_q;

    // Drop the result once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        div_n = in_val;
        div_d = in_mod;
        if (in_i.valid) begin
          m_d = in_mod;
          if (in_mod == '0) begin
            res_d   = '0;
            flag_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            div_ctl.start = 1'b1;
            state_d       = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (div_sts.done) begin
          r0_d    = m_q;
          r1_d    = div_rem;
          s0_d    = '0;
          s1_d    = WIDTH'(1);
          neg0_d  = 1'b0;
          neg1_d  = 1'b0;
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (r1_q == '0) begin
          state_d = ST_FIN;
        end else begin
          div_ctl.start = 1'b1;
          state_d       = ST_ITER;
        end
      end
      ST_ITER: begin
        if (div_sts.done) begin
          r0_d    = r1_q;
          r1_d    = div_rem;
          s0_d    = s1_q;
          s1_d    = s0_q + div_prod;
          neg0_d  = neg1_q;
          neg1_d  = ~neg1_q;
          state_d = ST_LOOP;
        end
      end
      ST_FIN: begin
        if (r0_q != WIDTH'(1)) begin
          res_d   = '0;
          flag_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          // Coefficient never exceeds the modulus: one subtract reduces it
          s0_d    = (s0_q >= m_q) ? (s0_q - m_q) : s0_q;
          state_d = ST_SGN;
        end
      end
      ST_SGN: begin
        res_d   = (neg0_q && (s0_q != '0)) ? (m_q - s0_q) : s0_q;
        flag_d  = 1'b0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_inv_d   = res_q;
          out_flag_d  = flag_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold operands and coefficients
  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    r0_q       <= r0_d;
    r1_q       <= r1_d;
    s0_q       <= s0_d;
    s1_q       <= s1_d;
    neg0_q     <= neg0_d;
    neg1_q     <= neg1_d;
    res_q      <= res_d;
    flag_q     <= flag_d;
    out_inv_q  <= out_inv_d;
    out_flag_q <= out_flag_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.inverse    = MIU_FIELD_W'(out_inv_q);
  assign out_o.no_inverse = out_flag_q;

endmodule

### rtl/miu_div.sv
`timescale 1ns / 1ps

// Shared restoring divider, one quotient bit per cycle. Alongside the
// remainder it forms quotient * mult_i by Horner's rule (shift and add),
// truncated to WIDTH bits.
module miu_div import miu_pkg::*; #(
  parameter int unsigned WIDTH = MIU_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  miu_div_ctl_t     ctl_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  input  logic [WIDTH-1:0] mult_i,
  output miu_div_sts_t     sts_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [WIDTH-1:0] num_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] den_q;
  logic [WIDTH-1:0] mul_q;
  logic [WIDTH-1:0] acc_q;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             take;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem_q, num_q[WIDTH-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = (trial >= {1'b0, den_q});

  // Sequence the bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Advance remainder, dividend and product
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      mul_q <= mult_i;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      num_q <= {num_q[WIDTH-2:0], 1'b0};
      acc_q <= {acc_q[WIDTH-2:0], 1'b0} + (take ? mul_q : '0);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;
  assign prod_o     = acc_q;

endmodule

### rtl/miu_checker.sv
`timescale 1ns / 1ps

module miu_checker import miu_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [MIU_FIELD_W-1:0] out_inverse_i,
  input logic                   out_no_inverse_i
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_inverse_i) && $stable(out_no_inverse_i))
    else $error("result changed while stalled");

  // A missing inverse reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_no_inverse_i |-> out_inverse_i == '0)
    else $error("no_inverse with nonzero inverse");

  // An accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready after accepting an item");

  // A new result follows a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work");

endmodule

bind modular_inverse_unit_core miu_checker u_miu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_inverse_i    (out_o.inverse),
  .out_no_inverse_i (out_o.no_inverse)
);
